/* rtl/core/spd_pkg.sv */
`default_nettype none
package spd_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned StatusW = 2;
	localparam int unsigned CfgIdxW = 3;

	localparam logic [CfgIdxW-1:0] REG_HEADER_FIRST  = 3'd0;
	localparam logic [CfgIdxW-1:0] REG_HEADER_SECOND = 3'd1;
	localparam logic [CfgIdxW-1:0] REG_MAX_LENGTH    = 3'd2;
	localparam logic [CfgIdxW-1:0] REG_TIMEOUT_TICKS = 3'd3;
	localparam logic [CfgIdxW-1:0] REG_ATTEMPTS      = 3'd4;

	localparam logic [ByteW-1:0] RST_HEADER_FIRST  = 8'd0;
	localparam logic [ByteW-1:0] RST_HEADER_SECOND = 8'd0;
	localparam logic [ByteW-1:0] RST_MAX_LENGTH    = 8'hFF;
	localparam logic [ByteW-1:0] RST_TIMEOUT_TICKS = 8'd20;
	localparam logic [ByteW-1:0] RST_ATTEMPTS      = 8'd20;

	localparam logic [ByteW-1:0] SUM_BASE = 8'hFF;
	localparam logic [ByteW-1:0] IDLE_MAX = 8'hFF;

	localparam logic [StatusW-1:0] STAT_OK         = 2'd0;
	localparam logic [StatusW-1:0] STAT_NO_DATA    = 2'd1;
	localparam logic [StatusW-1:0] STAT_DATA_SIZE  = 2'd2;
	localparam logic [StatusW-1:0] STAT_HDR_NFOUND = 2'd3;

	localparam logic KIND_PAYLOAD = 1'b0;
	localparam logic KIND_END     = 1'b1;

	localparam logic CMD_BYTE = 1'b0;
	localparam logic CMD_TICK = 1'b1;

	typedef enum logic [2:0] {
		PH_HUNT1,
		PH_HUNT2,
		PH_CMD,
		PH_LEN,
		PH_DATA,
		PH_CSUM
	} phase_t;

	typedef struct packed {
		logic [ByteW-1:0] header_first;
		logic [ByteW-1:0] header_second;
		logic [ByteW-1:0] max_payload_length;
		logic [ByteW-1:0] byte_timeout_ticks;
		logic [ByteW-1:0] header_attempts;
	} cfg_t;

	typedef struct packed {
		logic               last;
		logic               checksum_match;
		logic [StatusW-1:0] status;
		logic [ByteW-1:0]   payload_length;
		logic [ByteW-1:0]   command_id;
		logic [ByteW-1:0]   payload_byte;
		logic               result_kind;
	} result_t;

endpackage
`default_nettype wire

/* rtl/core/spd_cfg_regs.sv */
`default_nettype none
module spd_cfg_regs
	import spd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               wr_en,
	input  wire logic [CfgIdxW-1:0] wr_index,
	input  wire logic [ByteW-1:0]   wr_data,
	output cfg_t                    cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.header_first       <= RST_HEADER_FIRST;
			cfg_q.header_second      <= RST_HEADER_SECOND;
			cfg_q.max_payload_length <= RST_MAX_LENGTH;
			cfg_q.byte_timeout_ticks <= RST_TIMEOUT_TICKS;
			cfg_q.header_attempts    <= RST_ATTEMPTS;
		end else if (wr_en) begin
			unique case (wr_index)
				REG_HEADER_FIRST:  cfg_q.header_first       <= wr_data;
				REG_HEADER_SECOND: cfg_q.header_second      <= wr_data;
				REG_MAX_LENGTH:    cfg_q.max_payload_length <= wr_data;
				REG_TIMEOUT_TICKS: cfg_q.byte_timeout_ticks <= wr_data;
				REG_ATTEMPTS:      cfg_q.header_attempts    <= wr_data;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule
`default_nettype wire

/* rtl/core/spd_frame_fsm.sv */
`default_nettype none
module spd_frame_fsm
	import spd_pkg::*;
(
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             step,
	input  wire logic             command,
	input  wire logic [ByteW-1:0] rx_byte,
	input  wire cfg_t             cfg,
	output logic                  res_valid,
	output result_t               res
);

	phase_t           phase_q, phase_nx;
	logic [ByteW-1:0] attempts_q, attempts_nx;
	logic [ByteW-1:0] cmd_q, cmd_nx;
	logic [ByteW-1:0] len_q, len_nx;
	logic [ByteW-1:0] rem_q, rem_nx;
	logic [ByteW-1:0] sum_q, sum_nx;
	logic [ByteW-1:0] idle_q, idle_nx;

	logic [ByteW-1:0] idle_inc;
	logic [ByteW-1:0] rem_dec;
	logic             fail;
	logic             restart;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT1;
			attempts_q <= RST_ATTEMPTS;
			cmd_q      <= '0;
			len_q      <= '0;
			rem_q      <= '0;
			sum_q      <= '0;
			idle_q     <= '0;
		end else if (step) begin
			phase_q    <= phase_nx;
			attempts_q <= attempts_nx;
			cmd_q      <= cmd_nx;
			len_q      <= len_nx;
			rem_q      <= rem_nx;
			sum_q      <= sum_nx;
			idle_q     <= idle_nx;
		end
	end

	always_comb begin
		phase_nx    = phase_q;
		attempts_nx = attempts_q;
		cmd_nx      = cmd_q;
		len_nx      = len_q;
		rem_nx      = rem_q;
		sum_nx      = sum_q;
		idle_nx     = idle_q;
		fail        = 1'b0;
		restart     = 1'b0;
		res_valid   = 1'b0;
		res         = '0;
		idle_inc    = (idle_q == IDLE_MAX) ? idle_q : idle_q + 8'd1;
		rem_dec     = (rem_q != '0) ? rem_q - 8'd1 : rem_q;

		if (command == CMD_TICK) begin
			idle_nx = idle_inc;
			if (idle_inc > cfg.byte_timeout_ticks) begin
				idle_nx = '0;
				if (phase_q == PH_HUNT1 || phase_q == PH_HUNT2) begin
					fail = 1'b1;
				end else begin
					res_valid       = 1'b1;
					res.result_kind = KIND_END;
					res.status      = STAT_NO_DATA;
					res.last        = 1'b1;
					restart         = 1'b1;
				end
			end
		end else begin
			idle_nx = '0;
			unique case (phase_q)
				PH_HUNT1: begin
					if (rx_byte == cfg.header_first) phase_nx = PH_HUNT2;
					else fail = 1'b1;
				end
				PH_HUNT2: begin
					if (rx_byte == cfg.header_second) begin
						phase_nx = PH_CMD;
						cmd_nx   = '0;
						len_nx   = '0;
					end else begin
						fail = 1'b1;
					end
				end
				PH_CMD: begin
					cmd_nx   = rx_byte;
					phase_nx = PH_LEN;
				end
				PH_LEN: begin
					len_nx = rx_byte;
					sum_nx = '0;
					if (rx_byte > cfg.max_payload_length) begin
						res_valid       = 1'b1;
						res.result_kind = KIND_END;
						res.status      = STAT_DATA_SIZE;
						res.last        = 1'b1;
						restart         = 1'b1;
					end else begin
						rem_nx   = rx_byte;
						phase_nx = (rx_byte == '0) ? PH_CSUM : PH_DATA;
					end
				end
				PH_DATA: begin
					sum_nx = sum_q + rx_byte;
					rem_nx = rem_dec;
					if (rem_dec == '0) phase_nx = PH_CSUM;
					res_valid        = 1'b1;
					res.result_kind  = KIND_PAYLOAD;
					res.payload_byte = rx_byte;
				end
				PH_CSUM: begin
					res_valid          = 1'b1;
					res.result_kind    = KIND_END;
					res.status         = STAT_OK;
					res.checksum_match = (rx_byte == SUM_BASE - sum_q);
					res.last           = 1'b1;
					restart            = 1'b1;
				end
				default: ;
			endcase
		end

		if (fail) begin
			phase_nx = PH_HUNT1;
			if (attempts_q <= 8'd1) begin
				cmd_nx          = '0;
				len_nx          = '0;
				res_valid       = 1'b1;
				res.result_kind = KIND_END;
				res.status      = STAT_HDR_NFOUND;
				res.last        = 1'b1;
				restart         = 1'b1;
			end else begin
				attempts_nx = attempts_q - 8'd1;
			end
		end

		if (restart) begin
			phase_nx    = PH_HUNT1;
			attempts_nx = cfg.header_attempts;
			rem_nx      = '0;
			sum_nx      = '0;
		end

		res.command_id     = cmd_nx;
		res.payload_length = len_nx;
	end

endmodule
`default_nettype wire

/* rtl/core/serial_packet_deframer_unit.sv */
`default_nettype none
// Serial packet deframer. Each input beat is either a received UART byte
// (s_tuser = 0, byte in s_tdata) or one time tick (s_tuser = 1). The unit hunts
// for the two configured header bytes, takes a command and a length byte, then
// streams payload bytes out (m_tuser = 0) and ends each packet or error with a
// status beat (m_tuser = 1, m_tlast = 1) carrying status and checksum match.
// Throughput is one input beat per cycle while the output is not stalled by m_tready;
// a beat's result passes through the input register, the phase machine and the
// result register. Configuration writes are taken on any cycle
// but must be made while the unit is idle.
module serial_packet_deframer_unit
	import spd_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_tvalid,
	output logic                    s_tready,
	input  wire logic [7:0]         s_tdata,   // [7:0] rx_byte
	input  wire logic               s_tuser,   // [0] command
	output logic                    m_tvalid,
	input  wire logic               m_tready,
	output logic [31:0]             m_tdata,   // [7:0] payload_byte, [15:8] command_id,
	                                           // [23:16] payload_length, [25:24] status,
	                                           // [26] checksum_match, [31:27] zero
	output logic                    m_tuser,   // [0] result_kind
	output logic                    m_tlast,
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [CfgIdxW-1:0] cfg_index,
	input  wire logic [ByteW-1:0]   cfg_data
);

	cfg_t             cfg;
	logic             in_valid_s1;
	logic             command_s1;
	logic [ByteW-1:0] rx_byte_s1;
	logic             out_valid_q;
	result_t          out_q;
	logic             out_free;
	logic             step;
	logic             res_valid;
	result_t          res;

	assign cfg_ready = 1'b1;

	spd_cfg_regs u_cfg (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (cfg_valid & cfg_ready),
		.wr_index (cfg_index),
		.wr_data  (cfg_data),
		.cfg      (cfg)
	);

	assign out_free = !out_valid_q || m_tready;
	assign step     = in_valid_s1 && out_free;
	assign s_tready = !in_valid_s1 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_valid_s1 <= 1'b0;
		end else if (s_tready) begin
			in_valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			command_s1 <= s_tuser;
			rx_byte_s1 <= s_tdata;
		end
	end

	spd_frame_fsm u_fsm (
		.clk       (clk),
		.arst_n    (arst_n),
		.step      (step),
		.command   (command_s1),
		.rx_byte   (rx_byte_s1),
		.cfg       (cfg),
		.res_valid (res_valid),
		.res       (res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= step && res_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (out_free && step && res_valid) begin
			out_q <= res;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_q.result_kind;
	assign m_tlast  = out_q.last;
	assign m_tdata  = {5'd0, out_q.checksum_match, out_q.status, out_q.payload_length,
		out_q.command_id, out_q.payload_byte};

endmodule
`default_nettype wire

/* tb/sv/tb_serial_packet_deframer_unit.sv */
`timescale 1ns / 1ps

module tb_serial_packet_deframer_unit;
	import spd_pkg::*;

	localparam logic [CfgIdxW-1:0] REG_UNUSED = 3'd7;
	localparam int unsigned QUIET_LIMIT = 4000;
	localparam int unsigned DRAIN_CYCLES = 6;
	localparam int unsigned BYTES_PER_SETTING = 30;

	typedef enum {ROW_PREDICT, ROW_QUIET, ROW_TYPED} row_chk_t;

	typedef struct {
		logic       cmd;
		logic [7:0] rx;
		row_chk_t   chk;
		result_t    res;
	} stim_row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_tvalid = 1'b0;
	logic               s_tready;
	logic [7:0]         s_tdata = '0;
	logic               s_tuser = 1'b0;
	logic               m_tvalid;
	logic               m_tready = 1'b0;
	logic [31:0]        m_tdata;
	logic               m_tuser;
	logic               m_tlast;
	logic               cfg_valid = 1'b0;
	logic               cfg_ready;
	logic [CfgIdxW-1:0] cfg_index = '0;
	logic [ByteW-1:0]   cfg_data = '0;

	int send_idle = 0;
	int recv_idle = 0;
	int unsigned mismatch_cnt = 0;
	int unsigned byte_cnt = 0;
	int unsigned quiet_cycles = 0;

	result_t   result_fifo[$];
	result_t   next_result;
	stim_row_t directed_rows[$];

	logic [7:0] cfg_first = RST_HEADER_FIRST;
	logic [7:0] cfg_second = RST_HEADER_SECOND;
	logic [7:0] cfg_max = RST_MAX_LENGTH;
	logic [7:0] cfg_timeout = RST_TIMEOUT_TICKS;
	logic [7:0] cfg_tries = RST_ATTEMPTS;

	phase_t     ph = PH_HUNT1;
	logic [7:0] tries_left = RST_ATTEMPTS;
	logic [7:0] cur_cmd = '0;
	logic [7:0] cur_len = '0;
	logic [7:0] left_bytes = '0;
	logic [7:0] sum_acc = '0;
	logic [7:0] idle_cnt = '0;

	serial_packet_deframer_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	always #1 clk = ~clk;

	function automatic result_t make_end(input logic [7:0] cmd_id, input logic [7:0] len,
			input logic [StatusW-1:0] st, input logic sum_ok);
		result_t r;
		r = '0;
		r.result_kind = KIND_END;
		r.command_id = cmd_id;
		r.payload_length = len;
		r.status = st;
		r.checksum_match = sum_ok;
		r.last = 1'b1;
		return r;
	endfunction

	function automatic void rehunt();
		ph = PH_HUNT1;
		tries_left = cfg_tries;
		left_bytes = '0;
		sum_acc = '0;
	endfunction

	function automatic bit miss_attempt(output result_t r);
		r = '0;
		ph = PH_HUNT1;
		if (tries_left <= 8'd1) begin
			cur_cmd = '0;
			cur_len = '0;
			r = make_end(cur_cmd, cur_len, STAT_HDR_NFOUND, 1'b0);
			rehunt();
			return 1'b1;
		end
		tries_left = tries_left - 8'd1;
		return 1'b0;
	endfunction

	function automatic bit deframe_step(input logic cmd, input logic [7:0] rx,
			output result_t r);
		logic [7:0] want_sum;
		r = '0;
		if (cmd == CMD_TICK) begin
			if (idle_cnt != IDLE_MAX)
				idle_cnt = idle_cnt + 8'd1;
			if (idle_cnt <= cfg_timeout)
				return 1'b0;
			idle_cnt = '0;
			if (ph == PH_HUNT1 || ph == PH_HUNT2)
				return miss_attempt(r);
			r = make_end(cur_cmd, cur_len, STAT_NO_DATA, 1'b0);
			rehunt();
			return 1'b1;
		end
		idle_cnt = '0;
		case (ph)
			PH_HUNT1: begin
				if (rx != cfg_first)
					return miss_attempt(r);
				ph = PH_HUNT2;
				return 1'b0;
			end
			PH_HUNT2: begin
				if (rx != cfg_second)
					return miss_attempt(r);
				ph = PH_CMD;
				cur_cmd = '0;
				cur_len = '0;
				return 1'b0;
			end
			PH_CMD: begin
				cur_cmd = rx;
				ph = PH_LEN;
				return 1'b0;
			end
			PH_LEN: begin
				cur_len = rx;
				sum_acc = '0;
				if (rx > cfg_max) begin
					r = make_end(cur_cmd, cur_len, STAT_DATA_SIZE, 1'b0);
					rehunt();
					return 1'b1;
				end
				left_bytes = rx;
				ph = (rx == 8'd0) ? PH_CSUM : PH_DATA;
				return 1'b0;
			end
			PH_DATA: begin
				sum_acc = sum_acc + rx;
				if (left_bytes != 8'd0)
					left_bytes = left_bytes - 8'd1;
				if (left_bytes == 8'd0)
					ph = PH_CSUM;
				r.result_kind = KIND_PAYLOAD;
				r.payload_byte = rx;
				r.command_id = cur_cmd;
				r.payload_length = cur_len;
				r.status = STAT_OK;
				return 1'b1;
			end
			default: begin
				want_sum = SUM_BASE - sum_acc;
				r = make_end(cur_cmd, cur_len, STAT_OK, rx == want_sum);
				rehunt();
				return 1'b1;
			end
		endcase
	endfunction

	task automatic report_mismatch(input string msg);
		$display("MISMATCH at %0t: %s", $time, msg);
		mismatch_cnt++;
	endtask

	task automatic check_field(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			report_mismatch($sformatf("%s got 0x%0h want 0x%0h", name, got, want));
	endtask

	task automatic send_beat(input logic cmd, input logic [7:0] rx);
		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= cmd;
		s_tdata <= rx;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
	endtask

	task automatic feed(input logic cmd, input logic [7:0] rx);
		result_t r;
		send_beat(cmd, rx);
		if (deframe_step(cmd, rx, r))
			result_fifo.push_back(r);
		if (cmd == CMD_BYTE)
			byte_cnt++;
	endtask

	task automatic cfg_write(input logic [CfgIdxW-1:0] idx, input logic [7:0] val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		while (!cfg_ready)
			@(posedge clk);
		case (idx)
			REG_HEADER_FIRST:  cfg_first = val;
			REG_HEADER_SECOND: cfg_second = val;
			REG_MAX_LENGTH:    cfg_max = val;
			REG_TIMEOUT_TICKS: cfg_timeout = val;
			REG_ATTEMPTS:      cfg_tries = val;
			default: ;
		endcase
	endtask

	task automatic load_settings(input logic [7:0] first, input logic [7:0] second,
			input logic [7:0] maxlen, input logic [7:0] timeout, input logic [7:0] tries);
		cfg_write(REG_HEADER_FIRST, first);
		cfg_write(REG_HEADER_SECOND, second);
		cfg_write(REG_MAX_LENGTH, maxlen);
		cfg_write(REG_TIMEOUT_TICKS, timeout);
		cfg_write(REG_ATTEMPTS, tries);
		cfg_valid <= 1'b0;
	endtask

	task automatic settle();
		s_tvalid <= 1'b0;
		while (result_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic add_row(input logic cmd, input logic [7:0] rx, input row_chk_t chk,
			input result_t res);
		stim_row_t row;
		row.cmd = cmd;
		row.rx = rx;
		row.chk = chk;
		row.res = res;
		directed_rows.push_back(row);
	endtask

	task automatic random_frame();
		int unsigned pick;
		int unsigned cap;
		int unsigned n;
		logic [7:0] len;
		logic [7:0] b;
		logic [7:0] csum;
		pick = $urandom_range(99);
		if (pick < 12) begin
			repeat ($urandom_range(4, 1)) begin
				if ($urandom_range(3) == 0)
					feed(CMD_TICK, 8'($urandom_range(255)));
				else
					feed(CMD_BYTE, 8'($urandom_range(255)));
			end
			return;
		end
		feed(CMD_BYTE, cfg_first);
		if (pick < 17) begin
			feed(CMD_BYTE, cfg_second ^ 8'($urandom_range(255, 1)));
			return;
		end
		feed(CMD_BYTE, cfg_second);
		feed(CMD_BYTE, 8'($urandom_range(255)));
		cap = (cfg_max < 8'd12) ? cfg_max : 12;
		if (pick < 23 && cfg_max != 8'hFF)
			len = 8'($urandom_range(255, cfg_max + 1));
		else if (pick < 27)
			len = 8'($urandom_range(cfg_max));
		else
			len = 8'($urandom_range(cap));
		feed(CMD_BYTE, len);
		if (len > cfg_max)
			return;
		csum = SUM_BASE;
		for (int k = 0; k < len; k++) begin
			if ($urandom_range(7) == 0) begin
				n = $urandom_range((cfg_timeout < 8'd3) ? cfg_timeout : 3);
				repeat (n) feed(CMD_TICK, 8'($urandom_range(255)));
			end
			b = 8'($urandom_range(255));
			csum = csum - b;
			feed(CMD_BYTE, b);
		end
		if (pick < 33) begin
			repeat (int'(cfg_timeout) + 1) feed(CMD_TICK, 8'($urandom_range(255)));
			return;
		end
		feed(CMD_BYTE, ($urandom_range(3) != 0) ? csum : 8'($urandom_range(255)));
	endtask

	always @(posedge clk)
		m_tready <= ($urandom_range(99) >= recv_idle);

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (result_fifo.size() == 0) begin
				report_mismatch("result beat with no result expected");
			end else begin
				next_result = result_fifo.pop_front();
				check_field("result_kind", 32'(m_tuser), 32'(next_result.result_kind));
				check_field("payload_byte", 32'(m_tdata[7:0]),
					32'(next_result.payload_byte));
				check_field("command_id", 32'(m_tdata[15:8]), 32'(next_result.command_id));
				check_field("payload_length", 32'(m_tdata[23:16]),
					32'(next_result.payload_length));
				check_field("status", 32'(m_tdata[25:24]), 32'(next_result.status));
				check_field("checksum_match", 32'(m_tdata[26]),
					32'(next_result.checksum_match));
				check_field("last", 32'(m_tlast), 32'(next_result.last));
			end
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= QUIET_LIMIT) begin
			$display("serial_packet_deframer_unit test failed");
			$finish;
		end
	end

	initial begin
		result_t r;
		bit has;
		int unsigned target;
		logic [7:0] v;

		send_idle = 33;
		recv_idle = 79;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		load_settings(8'hA5, 8'h5A, 8'd4, 8'd1, 8'd2);

		// zero length, checksum against 0xFF
		add_row(CMD_BYTE, 8'hA5, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h5A, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'hFF, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h00, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'hFF, ROW_TYPED, make_end(8'hFF, 8'h00, STAT_OK, 1'b1));
		// length above the maximum
		add_row(CMD_BYTE, 8'hA5, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h5A, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h00, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h05, ROW_TYPED, make_end(8'h00, 8'h05, STAT_DATA_SIZE, 1'b0));
		// two payload bytes with a matching checksum
		add_row(CMD_BYTE, 8'hA5, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h5A, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h7E, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h02, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h80, ROW_PREDICT, '0);
		add_row(CMD_BYTE, 8'hFF, ROW_PREDICT, '0);
		add_row(CMD_BYTE, 8'h80, ROW_PREDICT, '0);
		// attempts used up
		add_row(CMD_BYTE, 8'h00, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h11, ROW_TYPED, make_end(8'h00, 8'h00, STAT_HDR_NFOUND, 1'b0));
		// timeout while hunting, then timeout after the header
		add_row(CMD_BYTE, 8'hA5, ROW_QUIET, '0);
		add_row(CMD_TICK, 8'h00, ROW_QUIET, '0);
		add_row(CMD_TICK, 8'hFF, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'hA5, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h5A, ROW_QUIET, '0);
		add_row(CMD_BYTE, 8'h33, ROW_QUIET, '0);
		add_row(CMD_TICK, 8'h00, ROW_QUIET, '0);
		add_row(CMD_TICK, 8'hFF, ROW_TYPED, make_end(8'h33, 8'h00, STAT_NO_DATA, 1'b0));

		foreach (directed_rows[i]) begin
			send_beat(directed_rows[i].cmd, directed_rows[i].rx);
			has = deframe_step(directed_rows[i].cmd, directed_rows[i].rx, r);
			case (directed_rows[i].chk)
				ROW_PREDICT: begin
					if (has)
						result_fifo.push_back(r);
				end
				ROW_TYPED: result_fifo.push_back(directed_rows[i].res);
				default: ;
			endcase
		end

		for (int setting = 0; setting < 6; setting++) begin
			if (setting == 2) begin
				send_idle = 79;
				recv_idle = 33;
			end
			if (setting == 4) begin
				send_idle = 0;
				recv_idle = 0;
			end
			settle();
			case (setting)
				0: begin
					cfg_write(REG_UNUSED, 8'($urandom_range(255)));
					load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
						8'hFF, 8'hFF, 8'hFF);
				end
				1: begin
					v = 8'($urandom_range(255));
					load_settings(v, v, 8'd0, 8'd1, 8'd1);
				end
				2: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'd16, 8'd0, 8'd0);
				3: load_settings(8'h00, 8'hFF, 8'd8, 8'd5, 8'd3);
				4: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'($urandom_range(40, 1)), 8'($urandom_range(10, 1)),
					8'($urandom_range(8, 1)));
				default: load_settings(8'($urandom_range(255)), 8'($urandom_range(255)),
					8'hFF, 8'($urandom_range(6, 2)), 8'($urandom_range(20, 2)));
			endcase
			// idle counter saturates without ever timing out
			if (setting == 0)
				repeat (260) feed(CMD_TICK, 8'($urandom_range(255)));
			target = byte_cnt + BYTES_PER_SETTING;
			while (byte_cnt < target)
				random_frame();
		end

		settle();
		if (mismatch_cnt == 0)
			$display("serial_packet_deframer_unit test passed");
		else
			$display("serial_packet_deframer_unit test failed");
		$finish;
	end

endmodule

/* serial_packet_deframer_unit.f */
rtl/core/spd_pkg.sv
rtl/core/spd_cfg_regs.sv
rtl/core/spd_frame_fsm.sv
rtl/core/serial_packet_deframer_unit.sv
tb/sv/tb_serial_packet_deframer_unit.sv
